// File: rtl/core/wsm_pkg.sv
// Shared types, constants and wheel helpers for the wheel sieve start block.
// Used by wsm_divider, wsm_mulsat and wheel_sieve_start_multiple.
`timescale 1ns / 1ps

package wsm_pkg;

    localparam int PRIME_W = 32;
    localparam int START_W = 64;
    localparam int MOD_W   = 5;
    localparam int STEP_W  = 3;

    localparam logic [MOD_W-1:0] WHEEL_MOD = 5'd30;

    // Divider results handed to the sequencer
    typedef struct packed {
        logic               done;
        logic [START_W-1:0] quot;
        logic               rem_nz;
        logic [MOD_W-1:0]   q_mod;
        logic [MOD_W-1:0]   p_mod;
    } div_res_t;

    // Multiplier results handed to the sequencer
    typedef struct packed {
        logic               done;
        logic [START_W-1:0] product;
        logic               ovf;
    } mul_res_t;

    // Distance from a residue mod 30 up to the nearest residue at or above it that is coprime to 30
    function automatic logic [STEP_W-1:0] wheel_step(input logic [MOD_W-1:0] r);
        logic [STEP_W-1:0] s;
        unique case (r)
            5'd0, 5'd6, 5'd10, 5'd12, 5'd16, 5'd18, 5'd22, 5'd28: s = 3'd1;
            5'd5, 5'd9, 5'd15, 5'd21, 5'd27:                      s = 3'd2;
            5'd4, 5'd8, 5'd14, 5'd20, 5'd26:                      s = 3'd3;
            5'd3, 5'd25:                                          s = 3'd4;
            5'd2, 5'd24:                                          s = 3'd5;
            default:                                              s = 3'd0;
        endcase
        return s;
    endfunction

    // One MSB-first digit of a running mod-30 reduction: (2r + b) mod 30
    function automatic logic [MOD_W-1:0] mod30_shift(input logic [MOD_W-1:0] r,
                                                     input logic b);
        logic [MOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, WHEEL_MOD}) begin
            t = t - {1'b0, WHEEL_MOD};
        end
        return t[MOD_W-1:0];
    endfunction

endpackage

// File: rtl/core/wsm_divider.sv
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Also reduces the quotient and the divisor mod 30 as their bits go by. Uses wsm_pkg.
`timescale 1ns / 1ps

module wsm_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wsm_pkg::START_W-1:0]       dividend,
    input  logic [wsm_pkg::PRIME_W-1:0]       divisor,
    output wsm_pkg::div_res_t                 res
);
    import wsm_pkg::*;

    localparam int CNT_W = $clog2(START_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [START_W-1:0] dq_reg;
    logic [PRIME_W-1:0] rem_reg;
    logic [PRIME_W-1:0] div_reg;
    logic [PRIME_W-1:0] psh_reg;
    logic [MOD_W-1:0]   qm_reg;
    logic [MOD_W-1:0]   pm_reg;

    logic [PRIME_W:0]   trial;
    logic [PRIME_W:0]   diff;
    logic               ge;

    // Shared subtract/compare of the partial remainder
    assign trial = {rem_reg, dq_reg[START_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(START_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bit in, remainder update, mod-30 tracking
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            psh_reg <= divisor;
            qm_reg  <= '0;
            pm_reg  <= '0;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[START_W-2:0], ge};
            rem_reg <= ge ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
            qm_reg  <= mod30_shift(qm_reg, ge);
            // divisor bits go by during the first half only
            if (cnt_reg < CNT_W'(PRIME_W)) begin
                pm_reg  <= mod30_shift(pm_reg, psh_reg[PRIME_W-1]);
                psh_reg <= {psh_reg[PRIME_W-2:0], 1'b0};
            end
        end
    end

    assign res.done   = done_reg;
    assign res.quot   = dq_reg;
    assign res.rem_nz = (rem_reg != '0);
    assign res.q_mod  = qm_reg;
    assign res.p_mod  = pm_reg;

    // Remainder is always below the divisor
    a_rem_lt_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // Done follows the last busy cycle
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a preceding busy cycle");

    // Start is never issued mid-division
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

endmodule

// File: rtl/core/wsm_mulsat.sv
// 64 x 32 multiply with overflow detect, two passes through one 32 x 32 multiplier.
// Saturation is applied by the caller from the overflow flag. Uses wsm_pkg.
`timescale 1ns / 1ps

module wsm_mulsat (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wsm_pkg::START_W-1:0]       mult,
    input  logic [wsm_pkg::PRIME_W-1:0]       prime,
    output wsm_pkg::mul_res_t                 res
);
    import wsm_pkg::*;

    localparam int HALF_W = START_W / 2;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_SUM
    } mul_state_t;

    mul_state_t                 state_reg;
    logic                       done_reg;
    logic [START_W-1:0]         a_reg;
    logic [PRIME_W-1:0]         b_reg;
    logic [HALF_W+PRIME_W-1:0]  lo_reg;
    logic [HALF_W+PRIME_W-1:0]  hi_reg;
    logic [START_W-1:0]         prod_reg;
    logic                       ovf_reg;

    logic [HALF_W-1:0]          op_a;
    logic [HALF_W+PRIME_W-1:0]  mprod;
    logic [HALF_W+PRIME_W:0]    sum;

    // Shared multiplier: low half first, then high half
    assign op_a  = (state_reg == MUL_LO) ? a_reg[HALF_W-1:0] : a_reg[START_W-1:HALF_W];
    assign mprod = op_a * b_reg;

    // Combine partial products; bits above 64 mean overflow
    assign sum = {1'b0, hi_reg} + {{(HALF_W+1){1'b0}}, lo_reg[HALF_W+PRIME_W-1:HALF_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MUL_IDLE: begin
                    if (start) begin
                        a_reg     <= mult;
                        b_reg     <= prime;
                        state_reg <= MUL_LO;
                    end
                end
                MUL_LO: begin
                    lo_reg    <= mprod;
                    state_reg <= MUL_HI;
                end
                MUL_HI: begin
                    hi_reg    <= mprod;
                    state_reg <= MUL_SUM;
                end
                MUL_SUM: begin
                    prod_reg  <= {sum[HALF_W-1:0], lo_reg[HALF_W-1:0]};
                    ovf_reg   <= (sum[HALF_W+PRIME_W:HALF_W] != '0);
                    done_reg  <= 1'b1;
                    state_reg <= MUL_IDLE;
                end
                default: state_reg <= MUL_IDLE;
            endcase
        end
    end

    assign res.done    = done_reg;
    assign res.product = prod_reg;
    assign res.ovf     = ovf_reg;

    // Done follows start through the MUL_LO, MUL_HI and MUL_SUM states, in that order
    a_done_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && state_reg == MUL_IDLE) |=> ##2 (state_reg == MUL_SUM) ##1 done_reg)
        else $error("multiplier done timing broken");

    // Start only arrives when idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == MUL_IDLE))
        else $error("multiplier started while busy");

    // No overflow with a zero high half
    a_ovf_hi_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MUL_SUM && a_reg[START_W-1:HALF_W] == '0) |=> !ovf_reg)
        else $error("overflow flagged for a 32-bit multiplier");

endmodule

// File: rtl/core/wheel_sieve_start_multiple.sv
// Top level of the mod-30 wheel sieve start offset block: sequencer and output register.
// Instantiates wsm_divider and wsm_mulsat; uses wsm_pkg.
//
// Use:
//   Input stream (s_): one transaction carries a sieving prime and a segment
//   start value; a start of zero selects the prime's square. Output stream
//   (m_): one transaction per input with the first multiple of the prime at
//   or after the start, multiplier >= prime and coprime to 30, the multiplier
//   mod 30, and an overflow flag in m_tuser (first multiple then reads all
//   ones). A zero prime returns multiple 0, residue 1, no overflow.
// Processing order:
//   from an input transaction to m_tvalid an item passes the bit-serial
//   divider (one quotient bit per cycle) and its done flag, rounding up and
//   clamping to the prime, the wheel step, the two-pass 64 x 32 multiply and
//   its done flag (skipped if the wheel step overflows), and the load of the
//   output register. s_tready is high only while idle, so one item is in
//   flight at a time and a new transaction is taken only once the last item
//   is in the output register. A zero prime goes straight to that load.
// Reset and stall:
//   aresetn (synchronous, active low) empties the block and drops m_tvalid.
//   A stalled receiver holds the result in the output register; the block
//   still takes and works the next item, then waits until the register frees.
`timescale 1ns / 1ps

module wheel_sieve_start_multiple (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] prime, [95:32] start_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] first_multiple, [68:64] multiplier_residue, pad
    output logic        m_tuser    // [0] overflow
);
    import wsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADJ,
        ST_WHEEL,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [PRIME_W-1:0] p_reg;
    logic [START_W-1:0] mult_reg;
    logic [MOD_W-1:0]   mod_reg;
    logic [START_W-1:0] res_mult_reg;
    logic [MOD_W-1:0]   res_mod_reg;
    logic               res_ovf_reg;
    logic               m_tvalid_reg;
    logic [START_W-1:0] m_mult_reg;
    logic [MOD_W-1:0]   m_mod_reg;
    logic               m_ovf_reg;

    logic [PRIME_W-1:0] in_prime;
    logic [START_W-1:0] in_start;
    logic               s_accept;
    logic               div_start;
    logic [START_W-1:0] dividend;
    div_res_t           div_res;
    mul_res_t           mul_res;
    logic [START_W-1:0] ceil_q;
    logic [MOD_W-1:0]   ceil_mod;
    logic [STEP_W-1:0]  step;
    logic [START_W:0]   wheel_sum;
    logic [MOD_W:0]     res_sum;
    logic               mul_start;
    logic               out_free;

    assign in_prime = s_tdata[PRIME_W-1:0];
    assign in_start = s_tdata[PRIME_W+START_W-1:PRIME_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // A zero start runs p / p, which then clamps to the prime itself
    assign div_start = s_accept && (in_prime != '0);
    assign dividend  = (in_start == '0) ? {{(START_W-PRIME_W){1'b0}}, in_prime} : in_start;

    wsm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (in_prime),
        .res      (div_res)
    );

    // Round the quotient up; its residue follows
    assign ceil_q   = div_res.quot + {{(START_W-1){1'b0}}, div_res.rem_nz};
    assign ceil_mod = !div_res.rem_nz ? div_res.q_mod :
                      (div_res.q_mod == WHEEL_MOD - 5'd1) ? '0 : div_res.q_mod + 5'd1;

    // Wheel step: raise to the nearest multiplier at or above that is coprime to 30
    assign step      = wheel_step(mod_reg);
    assign wheel_sum = {1'b0, mult_reg} + {{(START_W-STEP_W+1){1'b0}}, step};
    assign res_sum   = {1'b0, mod_reg} + {{(MOD_W-STEP_W+1){1'b0}}, step};
    assign mul_start = (state_reg == ST_WHEEL) && !wheel_sum[START_W];

    wsm_mulsat u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mult    (wheel_sum[START_W-1:0]),
        .prime   (p_reg),
        .res     (mul_res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // valid set on load, cleared on the output transaction
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        p_reg <= in_prime;
                        if (in_prime == '0) begin
                            res_mult_reg <= '0;
                            res_mod_reg  <= 5'd1;
                            res_ovf_reg  <= 1'b0;
                            state_reg    <= ST_DONE;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        state_reg <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    // at least the prime itself
                    if (ceil_q < {{(START_W-PRIME_W){1'b0}}, p_reg}) begin
                        mult_reg <= {{(START_W-PRIME_W){1'b0}}, p_reg};
                        mod_reg  <= div_res.p_mod;
                    end else begin
                        mult_reg <= ceil_q;
                        mod_reg  <= ceil_mod;
                    end
                    state_reg <= ST_WHEEL;
                end
                ST_WHEEL: begin
                    res_mod_reg <= (res_sum >= {1'b0, WHEEL_MOD}) ?
                                   res_sum[MOD_W-1:0] - WHEEL_MOD : res_sum[MOD_W-1:0];
                    if (wheel_sum[START_W]) begin
                        res_mult_reg <= '1;
                        res_ovf_reg  <= 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_res.done) begin
                        res_mult_reg <= mul_res.ovf ? '1 : mul_res.product;
                        res_ovf_reg  <= mul_res.ovf;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_mult_reg   <= res_mult_reg;
                        m_mod_reg    <= res_mod_reg;
                        m_ovf_reg    <= res_ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_mod_reg, m_mult_reg};
    assign m_tuser  = m_ovf_reg;

    // Overflow always comes with a saturated multiple
    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[63:0] == 64'hFFFF_FFFF_FFFF_FFFF))
        else $error("overflow result not saturated");

    // Residue is coprime to 30
    a_residue_coprime: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[68:64] == 5'd1 || m_tdata[68:64] == 5'd7 ||
                      m_tdata[68:64] == 5'd11 || m_tdata[68:64] == 5'd13 ||
                      m_tdata[68:64] == 5'd17 || m_tdata[68:64] == 5'd19 ||
                      m_tdata[68:64] == 5'd23 || m_tdata[68:64] == 5'd29))
        else $error("multiplier residue not coprime to 30");

    // One item in flight: busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again while an item is in flight");

endmodule
